### rtl/bplc_pkg.sv
`default_nettype none
package bplc_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Common width for comparing counts, positions and the capacity register.
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int VAL_W = 32;
  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef enum logic [2:0] {
    FN_INS_HEAD = 3'd0,
    FN_INS_TAIL = 3'd1,
    FN_INS_AT   = 3'd2,
    FN_REM_HEAD = 3'd3,
    FN_REM_TAIL = 3'd4,
    FN_REM_AT   = 3'd5,
    FN_SEARCH   = 3'd6
  } bplc_func_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } bplc_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_RESP
  } bplc_state_e;

  typedef struct packed {
    logic [2:0]        func;
    logic signed [31:0] value;
    logic [5:0]        position;
  } bplc_in_t;

  typedef struct packed {
    logic signed [31:0] removed_value;
    logic [5:0]        found_position;
    logic [1:0]        status;
    logic [6:0]        entry_count;
  } bplc_out_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic              cmp;
    logic [IDX_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  count;
  } bplc_cmd_t;

endpackage
`default_nettype wire

### rtl/bplc_cell.sv
`default_nettype none
module bplc_cell
  import bplc_pkg::*;
(
  input  wire logic             clk,
  input  wire bplc_cmd_t        cmd,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire logic [VAL_W-1:0] left_val,
  input  wire logic [VAL_W-1:0] right_val,
  output logic      [VAL_W-1:0] val_o,
  output logic      [VAL_W-1:0] sel_o,
  output logic                  match_o
);

  logic [VAL_W-1:0] val_r, val_nxt;
  logic             match_r;
  logic             at_pos, above_pos, in_list;

  assign at_pos    = (cell_idx == cmd.pos);
  assign above_pos = (cell_idx > cmd.pos);
  assign in_list   = (CMP_W'(cell_idx) < CMP_W'(cmd.count));

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (at_pos) begin
        val_nxt = cmd.value;
      end else if (above_pos) begin
        val_nxt = left_val;
      end
    end else if (cmd.rem) begin
      if (at_pos || above_pos) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (cmd.cmp) begin
      match_r <= in_list && (val_r == cmd.value);
    end
  end

  assign val_o   = val_r;
  assign sel_o   = at_pos ? val_r : '0;
  assign match_o = match_r;

endmodule
`default_nettype wire

### rtl/bplc_find.sv
`default_nettype none
module bplc_find
  import bplc_pkg::*;
(
  input  wire logic [DEPTH-1:0] match,
  output logic                  hit,
  output logic      [IDX_W-1:0] first_idx
);

  always_comb begin
    first_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  assign hit = |match;

endmodule
`default_nettype wire

### rtl/bounded_positional_list_core.sv
`default_nettype none
// Bounded positional list: an ordered list of up to DEPTH signed 32-bit values,
// held one entry per cell in a row of cells. Index 0 is the head. Inserts shift
// the cells above the position one place toward the tail, removes shift them one
// place toward the head, all cells moving in the same cycle. A search compares
// every cell against the key at once and a priority encoder picks the first hit.
// One item is worked at a time: an insert or remove passes accept, cell update
// and result register; a search also runs its registered match flags through
// the encoder first. The capacity register, written on the cfg port, lowers the
// entry limit (the user must write it only while the block is idle, which the
// block does not enforce); zero means always full, values above DEPTH mean DEPTH.
// Every input beat gives exactly one result beat carrying the removed value or
// found position, a status code and the entry count after the operation.
module bounded_positional_list_core
  import bplc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire bplc_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output bplc_out_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [6:0] cfg_data
);

  bplc_state_e state_r, state_nxt;

  logic [6:0]       cap_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Latched operation.
  logic [2:0]       op_func_r;
  logic [VAL_W-1:0] op_value_r;
  logic [5:0]       op_pos_r;

  // Result being assembled.
  logic [VAL_W-1:0] res_rv_r, res_rv_nxt;
  logic [5:0]       res_fp_r, res_fp_nxt;
  bplc_status_e     res_st_r, res_st_nxt;

  logic             out_valid_r;
  bplc_out_t        out_data_r;

  bplc_cmd_t        cmd;
  logic [VAL_W-1:0] cell_val [DEPTH];
  logic [VAL_W-1:0] cell_sel [DEPTH];
  logic [DEPTH-1:0] match;
  logic [VAL_W-1:0] sel_bus;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;

  // Operation decode, all in the common compare width.
  logic [CMP_W-1:0] cnt_w, limit_w, pos_w, tgt_w;
  logic             full, empty, is_ins, is_rem, ins_ok, rem_ok;
  logic             load_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  assign cnt_w   = CMP_W'(cnt_r);
  assign limit_w = (CMP_W'(cap_r) < CMP_W'(DEPTH)) ? CMP_W'(cap_r) : CMP_W'(DEPTH);
  assign pos_w   = CMP_W'(op_pos_r);
  assign full    = (cnt_w >= limit_w);
  assign empty   = (cnt_r == '0);

  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    tgt_w  = '0;
    unique case (op_func_r)
      FN_INS_HEAD: begin
        is_ins = 1'b1;
      end
      FN_INS_TAIL: begin
        is_ins = 1'b1;
        tgt_w  = cnt_w;
      end
      FN_INS_AT: begin
        is_ins = 1'b1;
        tgt_w  = pos_w;
      end
      FN_REM_HEAD: begin
        is_rem = 1'b1;
      end
      FN_REM_TAIL: begin
        is_rem = 1'b1;
        tgt_w  = cnt_w - CMP_W'(1);
      end
      FN_REM_AT: begin
        is_rem = 1'b1;
        tgt_w  = pos_w;
      end
      default: begin
      end
    endcase
  end

  assign ins_ok = is_ins && !full && (tgt_w <= cnt_w);
  assign rem_ok = is_rem && !empty && (tgt_w < cnt_w);

  // Broadcast to the cells; they only act while the operation executes.
  always_comb begin
    cmd.ins   = (state_r == S_EXEC) && ins_ok;
    cmd.rem   = (state_r == S_EXEC) && rem_ok;
    cmd.cmp   = (state_r == S_EXEC) && (op_func_r == FN_SEARCH);
    cmd.pos   = IDX_W'(tgt_w);
    cmd.value = op_value_r;
    cmd.count = cnt_r;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_v, right_v;
    if (i == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    bplc_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .cell_idx  (IDX_W'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .val_o     (cell_val[i]),
      .sel_o     (cell_sel[i]),
      .match_o   (match[i])
    );
  end

  // Only the cell at the target position drives a nonzero value here.
  always_comb begin
    sel_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_bus = sel_bus | cell_sel[i];
    end
  end

  bplc_find u_find (
    .match     (match),
    .hit       (hit),
    .first_idx (hit_idx)
  );

  // The result register may be loaded when it is empty or being drained.
  assign load_out = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    res_rv_nxt = res_rv_r;
    res_fp_nxt = res_fp_r;
    res_st_nxt = res_st_r;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_rv_nxt = '0;
        res_fp_nxt = '0;
        res_st_nxt = ST_DONE;
        state_nxt  = S_RESP;
        if (op_func_r == FN_SEARCH) begin
          state_nxt = S_SEARCH;
        end else if (is_ins) begin
          if (full) begin
            res_st_nxt = ST_FULL;
          end else if (!ins_ok) begin
            res_st_nxt = ST_RANGE;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else if (is_rem) begin
          if (empty) begin
            res_st_nxt = ST_EMPTY;
          end else if (!rem_ok) begin
            res_st_nxt = ST_RANGE;
          end else begin
            res_rv_nxt = sel_bus;
            cnt_nxt    = cnt_r - CNT_W'(1);
          end
        end
      end
      S_SEARCH: begin
        state_nxt = S_RESP;
        if (hit) begin
          res_st_nxt = ST_DONE;
          res_fp_nxt = 6'(hit_idx);
        end else begin
          res_st_nxt = ST_EMPTY;
        end
      end
      S_RESP: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_func_r  <= in_data.func;
      op_value_r <= in_data.value;
      op_pos_r   <= in_data.position;
    end
    res_rv_r <= res_rv_nxt;
    res_fp_r <= res_fp_nxt;
    res_st_r <= res_st_nxt;
    if (load_out) begin
      out_data_r.removed_value  <= res_rv_r;
      out_data_r.found_position <= res_fp_r;
      out_data_r.status         <= res_st_r;
      out_data_r.entry_count    <= 7'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### rtl/bplc_checker.sv
`default_nettype none
module bplc_checker
  import bplc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire bplc_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire bplc_out_t out_data,
  input wire logic      cfg_valid,
  input wire logic      cfg_ready,
  input wire logic [6:0] cfg_data
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // One item at a time: no second beat right after an accepted one.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // A refused operation never reports a removed value.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_DONE) |-> out_data.removed_value == '0)
    else $error("removed value on a refused operation");

  // A found position is only reported on success.
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.found_position != '0) |-> out_data.status == ST_DONE)
    else $error("found position without success");

endmodule

bind bounded_positional_list_core bplc_checker u_bplc_checker (.*);
`default_nettype wire
